@@ design/mso_pkg.sv @@
// Shared types for the merge sort unit.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package mso_pkg;

  localparam int KEY_W = 32;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_MERGE = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_SPARE = 5'b10000
  } state_t;

endpackage

`default_nettype wire

@@ design/mso_in_if.sv @@
// Input channel of the merge sort unit: valid/ready with key and last flag.
// Depends on mso_pkg.
`default_nettype none

interface mso_in_if;
  logic          valid;
  logic          ready;
  mso_pkg::key_t key;
  logic          last;

  modport source (output valid, output key, output last, input ready);
  modport sink   (input valid, input key, input last, output ready);
endinterface

`default_nettype wire

@@ design/mso_out_if.sv @@
// Result channel of the merge sort unit: valid/ready with sorted key and end flag.
// Depends on mso_pkg.
`default_nettype none

interface mso_out_if;
  logic          valid;
  logic          ready;
  mso_pkg::key_t sorted_key;
  logic          last_res;

  modport source (output valid, output sorted_key, output last_res, input ready);
  modport sink   (input valid, input sorted_key, input last_res, output ready);
endinterface

`default_nettype wire

@@ design/merge_sort_ordered_unit.sv @@
// Merge sort unit: stores a key sequence, merge-sorts it bottom-up, emits it.
// Depends on mso_pkg, mso_in_if and mso_out_if.
//
//   channel  | dir | transfer when        | payload
//   in_ch    | in  | valid && ready       | key, last
//   out_ch   | out | valid && ready       | sorted_key, last_res
//   cfg      | in  | cfg_we               | cfg_wdata (descending)
//
// Loading accepts one key per cycle. A sort of n keys runs ceil(log2 n) passes,
// each a start state, then a merge state writing via the single write port of
// the ping-pong memory it fills. Emission reads a key from memory and loads it
// into the output register before the next read; no input during sort/emit.
// Reset is synchronous; memories are not cleared, a stalled output holds.
`default_nettype none

module merge_sort_ordered_unit #(
  parameter int MAX_KEYS = 64
) (
  input  wire       clk,
  input  wire       rst_n,
  mso_in_if.sink    in_ch,
  mso_out_if.source out_ch,
  input  wire       cfg_we,
  input  wire       cfg_wdata
);

  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int AW = $clog2(MAX_KEYS);
  localparam int SW = CW + 2;

  function automatic logic [CW-1:0] clamp(input logic [SW-1:0] v, input logic [CW-1:0] n);
    logic [SW-1:0] nn;
    nn = SW'(n);
    clamp = (v > nn) ? n : v[CW-1:0];
  endfunction

  mso_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW:0]     w_r, w_nxt;
  logic [CW-1:0]   mid_r, mid_nxt, hi_r, hi_nxt;
  logic [CW-1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic            p_r, p_nxt;
  logic            rd_ok_r, rd_ok_nxt;
  logic            desc_r;
  logic            out_valid_r, out_valid_nxt;
  mso_pkg::key_t   out_key_r;
  logic            out_last_r;

  mso_pkg::key_t   mem0 [MAX_KEYS];
  mso_pkg::key_t   mem1 [MAX_KEYS];
  mso_pkg::key_t   rd0a_r, rd0b_r, rd1a_r, rd1b_r;
  mso_pkg::key_t   a_key, b_key, win_key;

  logic            in_xfer, ends, take_i, emit_ld;
  logic            we0, we1;
  logic [AW-1:0]   waddr;
  mso_pkg::key_t   wdata;
  logic [CW-1:0]   n_new;
  logic [SW-1:0]   w_ext, n_ext, k_inc;

  assign in_ch.ready       = (state_r == mso_pkg::ST_IDLE);
  assign in_xfer           = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sorted_key = out_key_r;
  assign out_ch.last_res   = out_last_r;

  assign a_key   = p_r ? rd1a_r : rd0a_r;
  assign b_key   = p_r ? rd1b_r : rd0b_r;
  assign take_i  = (i_r < mid_r) &&
                   ((j_r >= hi_r) || (desc_r ? (a_key > b_key) : (a_key < b_key)));
  assign win_key = take_i ? a_key : b_key;
  assign emit_ld = (state_r == mso_pkg::ST_EMIT) && rd_ok_r &&
                   (!out_valid_r || out_ch.ready);

  assign n_new = fill_r + CW'(1);
  assign ends  = in_ch.last || (n_new == CW'(MAX_KEYS));
  assign w_ext = SW'(w_r);
  assign n_ext = SW'(fill_r);
  assign k_inc = SW'(k_r) + SW'(1);

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    w_nxt     = w_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    we0       = 1'b0;
    we1       = 1'b0;
    waddr     = fill_r[AW-1:0];
    wdata     = in_ch.key;
    case (state_r)
      mso_pkg::ST_IDLE: begin
        if (in_xfer) begin
          we0      = 1'b1;
          fill_nxt = n_new;
          if (ends) begin
            w_nxt   = (CW+1)'(1);
            p_nxt   = 1'b0;
            k_nxt   = '0;
            i_nxt   = '0;
            mid_nxt = clamp(SW'(1), n_new);
            hi_nxt  = clamp(SW'(2), n_new);
            j_nxt   = clamp(SW'(1), n_new);
            state_nxt = (n_new == CW'(1)) ? mso_pkg::ST_EMIT : mso_pkg::ST_START;
          end
        end
      end
      mso_pkg::ST_START: begin
        state_nxt = mso_pkg::ST_MERGE;
      end
      mso_pkg::ST_MERGE: begin
        we0   = p_r;
        we1   = !p_r;
        waddr = k_r[AW-1:0];
        wdata = win_key;
        k_nxt = k_r + CW'(1);
        if (take_i) begin
          i_nxt = i_r + CW'(1);
        end else begin
          j_nxt = j_r + CW'(1);
        end
        if (k_inc == SW'(hi_r)) begin
          if (hi_r == fill_r) begin
            w_nxt = (CW+1)'(w_ext << 1);
            p_nxt = !p_r;
            k_nxt = '0;
            i_nxt = '0;
            if ((w_ext << 1) >= n_ext) begin
              state_nxt = mso_pkg::ST_EMIT;
            end else begin
              mid_nxt   = clamp(w_ext << 1, fill_r);
              hi_nxt    = clamp(w_ext << 2, fill_r);
              j_nxt     = clamp(w_ext << 1, fill_r);
              state_nxt = mso_pkg::ST_START;
            end
          end else begin
            i_nxt   = hi_r;
            mid_nxt = clamp(SW'(hi_r) + w_ext, fill_r);
            j_nxt   = clamp(SW'(hi_r) + w_ext, fill_r);
            hi_nxt  = clamp(SW'(hi_r) + (w_ext << 1), fill_r);
          end
        end
      end
      mso_pkg::ST_EMIT: begin
        if (emit_ld) begin
          i_nxt = i_r + CW'(1);
          if (n_new == fill_r + CW'(1) && (i_r + CW'(1)) == fill_r) begin
            fill_nxt  = '0;
            state_nxt = mso_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = mso_pkg::ST_IDLE;
      end
    endcase
  end

  assign rd_ok_nxt     = (state_r == mso_pkg::ST_EMIT) && (state_nxt == mso_pkg::ST_EMIT) &&
                         (i_nxt == i_r);
  assign out_valid_nxt = emit_ld ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mso_pkg::ST_IDLE;
      fill_r      <= '0;
      w_r         <= (CW+1)'(1);
      mid_r       <= '0;
      hi_r        <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      p_r         <= 1'b0;
      rd_ok_r     <= 1'b0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      w_r         <= w_nxt;
      mid_r       <= mid_nxt;
      hi_r        <= hi_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      p_r         <= p_nxt;
      rd_ok_r     <= rd_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        desc_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ld) begin
      out_key_r  <= a_key;
      out_last_r <= ((i_r + CW'(1)) == fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    rd0a_r <= mem0[i_nxt[AW-1:0]];
    rd0b_r <= mem0[j_nxt[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[waddr] <= wdata;
    end
    rd1a_r <= mem1[i_nxt[AW-1:0]];
    rd1b_r <= mem1[j_nxt[AW-1:0]];
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_KEYS))
    else $error("fill count above capacity");

  a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mso_pkg::ST_MERGE) |-> (i_r <= mid_r && j_r <= hi_r && k_r < hi_r))
    else $error("merge indices out of run");

  a_width_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mso_pkg::ST_MERGE || state_r == mso_pkg::ST_START) |->
      ($onehot(w_r) && w_ext < n_ext))
    else $error("merge width not a power of two below count");

  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ld |=> (out_valid_r && (out_last_r == (state_r == mso_pkg::ST_IDLE))))
    else $error("end flag does not match end of emission");

endmodule

`default_nettype wire

@@ verif/merge_sort_ordered_unit_test.sv @@
`timescale 1ns / 1ps
// Testbench for merge_sort_ordered_unit: directed and random key sequences, sorted
// both ways, checked result by result against an in-bench bottom-up merge sort.
// Depends on mso_pkg, mso_in_if, mso_out_if and the merge_sort_ordered_unit RTL.

module merge_sort_ordered_unit_test;

  localparam int            MAX_KEYS      = 64;
  localparam int            IDLE_PCT      = 28;
  localparam int            DRAIN_CYCLES  = 40000;
  localparam int            SETTLE_CYCLES = 24;
  localparam int            REPORT_LIMIT  = 10;
  localparam logic          ORDER_UP      = 1'b0;
  localparam logic          ORDER_DOWN    = 1'b1;
  localparam mso_pkg::key_t KEY_MAX       = 32'sh7fff_ffff;
  localparam mso_pkg::key_t KEY_MIN       = 32'sh8000_0000;

  typedef struct packed {
    mso_pkg::key_t key;
    logic          last;
  } key_item_t;

  typedef struct packed {
    mso_pkg::key_t sorted_key;
    logic          last_res;
  } sorted_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  mso_in_if  in_ch ();
  mso_out_if out_ch ();

  merge_sort_ordered_unit #(.MAX_KEYS(MAX_KEYS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  key_item_t     key_fifo[$];
  sorted_item_t  sorted_exp[$];
  mso_pkg::key_t run_keys[$];
  logic          desc_mode;
  logic          no_gaps;
  logic          in_taken;
  int            fail_count;
  int            keys_sent;
  int            keys_checked;
  int            runs_closed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("merge_sort_ordered_unit test failed");
    $finish;
  end

  function automatic bit goes_ahead(mso_pkg::key_t a, mso_pkg::key_t b);
    return desc_mode ? (a > b) : (a < b);
  endfunction

  // Sort the collected run bottom-up and queue it as expected output.
  task automatic close_run();
    mso_pkg::key_t scratch[MAX_KEYS];
    int            n, w, lo, mid, hi, i, j, k;
    n = run_keys.size();
    for (w = 1; w < n; w = w * 2) begin
      for (lo = 0; lo + w < n; lo = lo + 2 * w) begin
        mid = lo + w;
        hi  = (lo + 2 * w > n) ? n : lo + 2 * w;
        i   = lo;
        j   = mid;
        for (k = lo; k < hi; k++) begin
          if (j >= hi || (i < mid && goes_ahead(run_keys[i], run_keys[j]))) begin
            scratch[k] = run_keys[i];
            i++;
          end else begin
            scratch[k] = run_keys[j];
            j++;
          end
        end
        for (k = lo; k < hi; k++) run_keys[k] = scratch[k];
      end
    end
    for (k = 0; k < n; k++) sorted_exp.push_back('{run_keys[k], k == n - 1});
    run_keys.delete();
    runs_closed++;
  endtask

  task automatic flag_mismatch(string what, sorted_item_t want, sorted_item_t got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT)
      $display("%0t: %s: expected key %0d last %0b, got key %0d last %0b", $time, what,
               want.sorted_key, want.last_res, got.sorted_key, got.last_res);
  endtask

  always @(posedge clk) begin : watch_ports
    sorted_item_t got, want;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      desc_mode  = ORDER_UP;
      run_keys.delete();
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (cfg_we) desc_mode = cfg_wdata;
      if (in_ch.valid && in_ch.ready) begin
        run_keys.push_back(in_ch.key);
        if (in_ch.last || run_keys.size() >= MAX_KEYS) close_run();
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.sorted_key, out_ch.last_res};
        keys_checked++;
        if (sorted_exp.size() == 0) begin
          flag_mismatch("result with nothing pending", '0, got);
        end else begin
          want = sorted_exp.pop_front();
          if (got.sorted_key !== want.sorted_key)
            flag_mismatch("sorted_key differs", want, got);
          else if (got.last_res !== want.last_res)
            flag_mismatch("last_res differs", want, got);
        end
      end
    end
  end

  always @(negedge clk) begin : drive_keys
    key_item_t nxt;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.key    <= '0;
      in_ch.last   <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_taken) begin
        if (key_fifo.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = key_fifo.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.key   <= nxt.key;
          in_ch.last  <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic mso_pkg::key_t pick_key();
    case ($urandom_range(9))
      0:       return KEY_MAX;
      1:       return KEY_MIN;
      2, 3:    return mso_pkg::key_t'(int'($urandom_range(16)) - 8);
      default: return mso_pkg::key_t'($urandom);
    endcase
  endfunction

  task automatic push_key(mso_pkg::key_t k, logic l);
    key_fifo.push_back('{k, l});
    keys_sent++;
  endtask

  task automatic push_run(int n, logic mark_end);
    for (int i = 0; i < n; i++) push_key(pick_key(), mark_end && (i == n - 1));
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while ((key_fifo.size() > 0 || in_ch.valid || sorted_exp.size() > 0)
           && guard < DRAIN_CYCLES) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_order(logic d);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= d;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic push_directed();
    push_key(KEY_MIN, 1'b1);
    push_key(KEY_MAX, 1'b1);
    push_key(KEY_MAX, 1'b0);
    push_key(KEY_MIN, 1'b0);
    push_key(32'sd0, 1'b0);
    push_key(-32'sd1, 1'b0);
    push_key(32'sd1, 1'b1);
    push_key(32'sd7, 1'b0);
    push_key(-32'sd7, 1'b0);
    push_key(32'sd7, 1'b0);
    push_key(-32'sd7, 1'b1);
  endtask

  initial begin : stimulus
    logic order_plan[4];
    int   budget_plan[4];
    int   start_count;
    order_plan  = '{ORDER_UP, ORDER_DOWN, ORDER_UP, ORDER_DOWN};
    budget_plan = '{1, 6, 6, 6};
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    no_gaps      = 1'b0;
    fail_count   = 0;
    keys_sent    = 0;
    keys_checked = 0;
    runs_closed  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_order(ORDER_UP);
    push_directed();
    set_order(ORDER_DOWN);
    push_directed();

    for (int p = 0; p < 4; p++) begin
      set_order(order_plan[p]);
      // hold both sides busy for the whole first random phase
      no_gaps     = (p == 0);
      start_count = keys_sent;
      // fill the store without a last mark; the filling key ends the sequence
      if (p == 0) push_run(MAX_KEYS, 1'b0);
      while (keys_sent - start_count < budget_plan[p] + ((p == 0) ? MAX_KEYS : 0))
        push_run($urandom_range(1, 16), 1'b1);
      drain();
      no_gaps = 1'b0;
    end

    drain();
    fail_count += sorted_exp.size();
    $display("Sent %0d keys in %0d sequences, checked %0d sorted keys", keys_sent,
             runs_closed, keys_checked);
    $display("Covered both sort orders, key extremes, ties, single keys and full store");
    if (fail_count == 0) begin
      $display("merge_sort_ordered_unit test passed");
    end else begin
      $display("merge_sort_ordered_unit test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/mso_pkg.sv
design/mso_in_if.sv
design/mso_out_if.sv
design/merge_sort_ordered_unit.sv
verif/merge_sort_ordered_unit_test.sv
